>>> rtl/core/lbmd3q7_pkg.sv
// Shared types and constants for the D3Q7 collision kernel.
package lbmd3q7_pkg;

	localparam int NUM_DIR = 7;
	localparam int NUM_AXIS = 3;
	localparam int DIST_W = 18;
	localparam int DENS_W = 21;
	localparam int MOM_W = 19;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W = 2;

	localparam int DIST_MAX = 131071;
	localparam int DIST_MIN = -131072;

	// opposite direction for bounce-back: rest, +x, -x, +y, -y, +z, -z
	localparam int OPP [NUM_DIR] = '{0, 2, 1, 4, 3, 6, 5};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INV_TAU     = 2'd0,
		CFG_DAMPING     = 2'd1,
		CFG_C_SQUARED   = 2'd2,
		CFG_REST_WEIGHT = 2'd3
	} cfg_idx_t;

	localparam logic [15:0] INV_TAU_RST     = 16'd32768;
	localparam logic [14:0] DAMPING_RST     = 15'd14746;
	localparam logic [14:0] C_SQUARED_RST   = 15'd4096;
	localparam logic [14:0] REST_WEIGHT_RST = 15'd4096;

	typedef logic signed [DIST_W-1:0] dist_t;
	typedef logic signed [DENS_W-1:0] dens_t;
	typedef logic signed [MOM_W-1:0] mom_t;

endpackage

>>> rtl/core/lbm_d3q7_wave_collision_top.sv
// D3Q7 lattice-Boltzmann BGK collision / damped bounce-back kernel, one cell per item.
// Six registers from the accepting edge to out_valid: input reg, sums, products,
// equilibrium, relaxation product, round/saturate output reg.
// Throughput: one item per cycle; each stage holds only while its successor is full.
// Stalls fill bubbles first; in_stall rises only when all six stages hold items.
// Reset (arst_n low): all stage valid bits clear, config registers load their reset values.
module lbm_d3q7_wave_collision_top #(
	parameter int FRAC_BITS = 14
) (
	input  logic                                   clk,
	input  logic                                   arst_n,

	input  logic                                   cfg_we,
	input  logic [lbmd3q7_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lbmd3q7_pkg::CFG_DATA_W-1:0]     cfg_data,

	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [lbmd3q7_pkg::DIST_W-1:0]  dist_in_0,
	input  logic signed [lbmd3q7_pkg::DIST_W-1:0]  dist_in_1,
	input  logic signed [lbmd3q7_pkg::DIST_W-1:0]  dist_in_2,
	input  logic signed [lbmd3q7_pkg::DIST_W-1:0]  dist_in_3,
	input  logic signed [lbmd3q7_pkg::DIST_W-1:0]  dist_in_4,
	input  logic signed [lbmd3q7_pkg::DIST_W-1:0]  dist_in_5,
	input  logic signed [lbmd3q7_pkg::DIST_W-1:0]  dist_in_6,
	input  logic                                   at_wall,

	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [lbmd3q7_pkg::DIST_W-1:0]  dist_out_0,
	output logic signed [lbmd3q7_pkg::DIST_W-1:0]  dist_out_1,
	output logic signed [lbmd3q7_pkg::DIST_W-1:0]  dist_out_2,
	output logic signed [lbmd3q7_pkg::DIST_W-1:0]  dist_out_3,
	output logic signed [lbmd3q7_pkg::DIST_W-1:0]  dist_out_4,
	output logic signed [lbmd3q7_pkg::DIST_W-1:0]  dist_out_5,
	output logic signed [lbmd3q7_pkg::DIST_W-1:0]  dist_out_6,
	output logic signed [lbmd3q7_pkg::DENS_W-1:0]  density
);

	localparam int F   = FRAC_BITS;
	localparam int ND  = lbmd3q7_pkg::NUM_DIR;
	localparam int NA  = lbmd3q7_pkg::NUM_AXIS;
	localparam int DW  = lbmd3q7_pkg::DIST_W;
	localparam int RHW = lbmd3q7_pkg::DENS_W;
	// keep = one - inv_tau, also holds damping
	localparam int KW  = (F + 2 > 18) ? F + 2 : 18;
	localparam int PW  = KW + DW;
	// rest factor aux = one - round(4*c2*(one-rw))
	localparam int TW  = KW + 19 - F;
	localparam int AW  = ((F + 2 > TW) ? F + 2 : TW) + 1;
	localparam int RAW = RHW + AW;
	localparam int RW  = RAW + 1 - F;
	localparam int C2W = 16 + RHW;
	localparam int MSW = ((C2W > F + 20) ? C2W : F + 20) + 2;
	localparam int MW  = MSW - F - 1;
	localparam int EW  = (RW > MW) ? RW : MW;
	localparam int TFW = EW + 17;
	localparam int SW  = ((PW > TFW) ? PW : TFW) + 2;

	// configuration
	logic [15:0] inv_tau_q;
	logic [14:0] damping_q;
	logic [14:0] c_squared_q;
	logic [14:0] rest_weight_q;
	logic signed [AW-1:0] aux_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_tau_q     <= lbmd3q7_pkg::INV_TAU_RST;
			damping_q     <= lbmd3q7_pkg::DAMPING_RST;
			c_squared_q   <= lbmd3q7_pkg::C_SQUARED_RST;
			rest_weight_q <= lbmd3q7_pkg::REST_WEIGHT_RST;
		end else if (cfg_we) begin
			unique case (lbmd3q7_pkg::cfg_idx_t'(cfg_index))
				lbmd3q7_pkg::CFG_INV_TAU:     inv_tau_q     <= cfg_data;
				lbmd3q7_pkg::CFG_DAMPING:     damping_q     <= cfg_data[14:0];
				lbmd3q7_pkg::CFG_C_SQUARED:   c_squared_q   <= cfg_data[14:0];
				lbmd3q7_pkg::CFG_REST_WEIGHT: rest_weight_q <= cfg_data[14:0];
			endcase
		end
	end

	logic signed [KW-1:0]   one_k;
	logic signed [KW-1:0]   keep;
	logic signed [KW-1:0]   damp_k;
	logic signed [KW-1:0]   omr;
	logic signed [17:0]     c2x4;
	logic signed [KW+17:0]  aux_m;
	logic signed [KW+18:0]  aux_p;
	logic signed [KW+18:0]  aux_sh;
	logic signed [AW-1:0]   one_a;
	logic signed [AW-1:0]   aux_c;
	logic signed [15:0]     c2_s;
	logic signed [16:0]     tau_s;

	always_comb begin
		one_k  = KW'(1) <<< F;
		keep   = one_k - KW'({1'b0, inv_tau_q});
		damp_k = KW'({1'b0, damping_q});
		omr    = one_k - KW'({1'b0, rest_weight_q});
		c2x4   = {1'b0, c_squared_q, 2'b00};
		aux_m  = c2x4 * omr;
		aux_p  = (KW+19)'(aux_m) + ((KW+19)'(1) <<< (F - 1));
		aux_sh = aux_p >>> F;
		one_a  = AW'(1) <<< F;
		aux_c  = one_a - AW'(aux_sh);
		c2_s   = {1'b0, c_squared_q};
		tau_s  = {1'b0, inv_tau_q};
	end

	// refreshed every cycle; config is to move only while the pipe is empty, which the block itself does not enforce
	always_ff @(posedge clk) begin
		aux_q <= aux_c;
	end

	// stage valids and advance chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic adv1, adv2, adv3, adv4, adv5, adv6;

	assign adv6 = !v_s6 || !out_stall;
	assign adv5 = !v_s5 || adv6;
	assign adv4 = !v_s4 || adv5;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign in_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
			if (adv6) v_s6 <= v_s5;
		end
	end

	// stage 1: input register
	lbmd3q7_pkg::dist_t f_s1 [ND];
	logic               wall_s1;

	always_ff @(posedge clk) begin
		if (adv1) begin
			f_s1[0] <= dist_in_0;
			f_s1[1] <= dist_in_1;
			f_s1[2] <= dist_in_2;
			f_s1[3] <= dist_in_3;
			f_s1[4] <= dist_in_4;
			f_s1[5] <= dist_in_5;
			f_s1[6] <= dist_in_6;
			wall_s1 <= at_wall;
		end
	end

	// stage 2: density and axis momenta
	lbmd3q7_pkg::dens_t rho_c;
	lbmd3q7_pkg::mom_t  j_c [NA];

	always_comb begin
		rho_c = '0;
		for (int i = 0; i < ND; i++) begin
			rho_c = rho_c + RHW'(f_s1[i]);
		end
		for (int a = 0; a < NA; a++) begin
			j_c[a] = lbmd3q7_pkg::MOM_W'(f_s1[2*a+1]) - lbmd3q7_pkg::MOM_W'(f_s1[2*a+2]);
		end
	end

	lbmd3q7_pkg::dist_t f_s2 [ND];
	lbmd3q7_pkg::dens_t rho_s2;
	lbmd3q7_pkg::mom_t  j_s2 [NA];
	logic               wall_s2;

	always_ff @(posedge clk) begin
		if (adv2) begin
			f_s2    <= f_s1;
			rho_s2  <= rho_c;
			j_s2    <= j_c;
			wall_s2 <= wall_s1;
		end
	end

	// stage 3: keep*f or damping*f[opp], rho*aux, c2*rho
	logic signed [KW-1:0]  coef_c [ND];
	lbmd3q7_pkg::dist_t    opnd_c [ND];
	logic signed [PW-1:0]  prod_c [ND];
	logic signed [RAW-1:0] rhoaux_c;
	logic signed [C2W-1:0] c2rho_c;

	always_comb begin
		for (int i = 0; i < ND; i++) begin
			coef_c[i] = wall_s2 ? damp_k : keep;
			opnd_c[i] = wall_s2 ? f_s2[lbmd3q7_pkg::OPP[i]] : f_s2[i];
			prod_c[i] = coef_c[i] * opnd_c[i];
		end
		rhoaux_c = rho_s2 * aux_q;
		c2rho_c  = rho_s2 * c2_s;
	end

	logic signed [PW-1:0]  prod_s3 [ND];
	logic signed [RAW-1:0] rhoaux_s3;
	logic signed [C2W-1:0] c2rho_s3;
	lbmd3q7_pkg::mom_t     j_s3 [NA];
	lbmd3q7_pkg::dens_t    rho_s3;
	logic                  wall_s3;

	always_ff @(posedge clk) begin
		if (adv3) begin
			prod_s3   <= prod_c;
			rhoaux_s3 <= rhoaux_c;
			c2rho_s3  <= c2rho_c;
			j_s3      <= j_s2;
			rho_s3    <= rho_s2;
			wall_s3   <= wall_s2;
		end
	end

	// stage 4: equilibria, rounded to whole distribution units
	logic signed [RAW:0]   rest_p;
	logic signed [RAW:0]   rest_sh;
	logic signed [19:0]    jm_c [ND];
	logic signed [MSW-1:0] ms_c [ND];
	logic signed [MSW-1:0] ms_sh [ND];
	logic signed [EW-1:0]  feq_c [ND];

	always_comb begin
		rest_p   = (RAW+1)'(rhoaux_s3) + ((RAW+1)'(1) <<< (F - 1));
		rest_sh  = rest_p >>> F;
		feq_c[0] = EW'(rest_sh);
		jm_c[0]  = '0;
		ms_c[0]  = '0;
		ms_sh[0] = '0;
		for (int i = 1; i < ND; i++) begin
			// odd directions are the plus side of their axis
			if (i[0]) begin
				jm_c[i] = 20'(j_s3[(i-1) >> 1]);
			end else begin
				jm_c[i] = -20'(j_s3[(i-1) >> 1]);
			end
			ms_c[i]  = MSW'(c2rho_s3) + (MSW'(jm_c[i]) <<< F) + (MSW'(1) <<< F);
			ms_sh[i] = ms_c[i] >>> (F + 1);
			feq_c[i] = EW'(ms_sh[i]);
		end
	end

	logic signed [PW-1:0] prod_s4 [ND];
	logic signed [EW-1:0] feq_s4 [ND];
	lbmd3q7_pkg::dens_t   rho_s4;
	logic                 wall_s4;

	always_ff @(posedge clk) begin
		if (adv4) begin
			prod_s4 <= prod_s3;
			feq_s4  <= feq_c;
			rho_s4  <= rho_s3;
			wall_s4 <= wall_s3;
		end
	end

	// stage 5: inv_tau * feq
	logic signed [TFW-1:0] tf_c [ND];

	always_comb begin
		for (int i = 0; i < ND; i++) begin
			tf_c[i] = tau_s * feq_s4[i];
		end
	end

	logic signed [PW-1:0]  prod_s5 [ND];
	logic signed [TFW-1:0] tf_s5 [ND];
	lbmd3q7_pkg::dens_t    rho_s5;
	logic                  wall_s5;

	always_ff @(posedge clk) begin
		if (adv5) begin
			prod_s5 <= prod_s4;
			tf_s5   <= tf_c;
			rho_s5  <= rho_s4;
			wall_s5 <= wall_s4;
		end
	end

	// stage 6: sum, round, saturate into the output register
	logic signed [SW-1:0] tf_sel [ND];
	logic signed [SW-1:0] sum_c [ND];
	logic signed [SW-1:0] sh_c [ND];
	lbmd3q7_pkg::dist_t   res_c [ND];

	always_comb begin
		for (int i = 0; i < ND; i++) begin
			tf_sel[i] = wall_s5 ? SW'(0) : SW'(tf_s5[i]);
			sum_c[i]  = SW'(prod_s5[i]) + tf_sel[i] + (SW'(1) <<< (F - 1));
			sh_c[i]   = sum_c[i] >>> F;
			if (sh_c[i] > SW'(lbmd3q7_pkg::DIST_MAX)) begin
				res_c[i] = DW'(lbmd3q7_pkg::DIST_MAX);
			end else if (sh_c[i] < SW'(lbmd3q7_pkg::DIST_MIN)) begin
				res_c[i] = DW'(lbmd3q7_pkg::DIST_MIN);
			end else begin
				res_c[i] = DW'(sh_c[i]);
			end
		end
	end

	lbmd3q7_pkg::dist_t dist_s6 [ND];
	lbmd3q7_pkg::dens_t rho_s6;

	always_ff @(posedge clk) begin
		if (adv6) begin
			dist_s6 <= res_c;
			rho_s6  <= rho_s5;
		end
	end

	assign out_valid  = v_s6;
	assign dist_out_0 = dist_s6[0];
	assign dist_out_1 = dist_s6[1];
	assign dist_out_2 = dist_s6[2];
	assign dist_out_3 = dist_s6[3];
	assign dist_out_4 = dist_s6[4];
	assign dist_out_5 = dist_s6[5];
	assign dist_out_6 = dist_s6[6];
	assign density    = rho_s6;

	// checks
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> v_s1)
		else $error("accepted item did not reach stage 1");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && out_stall))
		else $error("input stalled while the pipeline has a bubble");

	a_held_stage_keeps_item: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !adv3) |=> v_s3)
		else $error("held stage 3 item lost");

	a_out_from_s5: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_s6) |-> $past(v_s5))
		else $error("output valid without an item in stage 5");

endmodule

>>> sim/lbm_d3q7_wave_collision_top_test.sv
// Self-checking testbench for the D3Q7 collision kernel with a fixed-point predictor.
`timescale 1ns / 100ps

module lbm_d3q7_wave_collision_top_test;

	localparam int FRAC = 14;
	localparam longint ONE = longint'(1) << FRAC;
	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD = 150;

	typedef struct packed {
		logic wall;
		lbmd3q7_pkg::dist_t [lbmd3q7_pkg::NUM_DIR-1:0] dirs;
	} cell_in_t;

	typedef struct packed {
		lbmd3q7_pkg::dens_t dens;
		lbmd3q7_pkg::dist_t [lbmd3q7_pkg::NUM_DIR-1:0] dirs;
	} cell_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	lbmd3q7_pkg::cfg_idx_t cfg_index = lbmd3q7_pkg::CFG_INV_TAU;
	logic [lbmd3q7_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	lbmd3q7_pkg::dist_t dist_in_0 = '0;
	lbmd3q7_pkg::dist_t dist_in_1 = '0;
	lbmd3q7_pkg::dist_t dist_in_2 = '0;
	lbmd3q7_pkg::dist_t dist_in_3 = '0;
	lbmd3q7_pkg::dist_t dist_in_4 = '0;
	lbmd3q7_pkg::dist_t dist_in_5 = '0;
	lbmd3q7_pkg::dist_t dist_in_6 = '0;
	logic at_wall = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	lbmd3q7_pkg::dist_t dist_out_0;
	lbmd3q7_pkg::dist_t dist_out_1;
	lbmd3q7_pkg::dist_t dist_out_2;
	lbmd3q7_pkg::dist_t dist_out_3;
	lbmd3q7_pkg::dist_t dist_out_4;
	lbmd3q7_pkg::dist_t dist_out_5;
	lbmd3q7_pkg::dist_t dist_out_6;
	lbmd3q7_pkg::dens_t density;

	// register shadows
	logic [15:0] tau_reg = lbmd3q7_pkg::INV_TAU_RST;
	logic [14:0] damp_reg = lbmd3q7_pkg::DAMPING_RST;
	logic [14:0] csq_reg = lbmd3q7_pkg::C_SQUARED_RST;
	logic [14:0] rest_reg = lbmd3q7_pkg::REST_WEIGHT_RST;

	cell_out_t expected_cells[$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int errors = 0;
	int cycle_count = 0;
	int cells_sent = 0;
	int wall_cells = 0;
	int results_checked = 0;
	int settings_used = 0;
	int input_stall_edges = 0;

	lbm_d3q7_wave_collision_top #(.FRAC_BITS(FRAC)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.dist_in_0(dist_in_0),
		.dist_in_1(dist_in_1),
		.dist_in_2(dist_in_2),
		.dist_in_3(dist_in_3),
		.dist_in_4(dist_in_4),
		.dist_in_5(dist_in_5),
		.dist_in_6(dist_in_6),
		.at_wall(at_wall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.dist_out_0(dist_out_0),
		.dist_out_1(dist_out_1),
		.dist_out_2(dist_out_2),
		.dist_out_3(dist_out_3),
		.dist_out_4(dist_out_4),
		.dist_out_5(dist_out_5),
		.dist_out_6(dist_out_6),
		.density(density)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic longint round_q(input longint x, input int k);
		return (x + (longint'(1) << (k - 1))) >>> k;
	endfunction

	function automatic lbmd3q7_pkg::dist_t clamp_dist(input longint x);
		if (x > lbmd3q7_pkg::DIST_MAX)
			return lbmd3q7_pkg::dist_t'(lbmd3q7_pkg::DIST_MAX);
		if (x < lbmd3q7_pkg::DIST_MIN)
			return lbmd3q7_pkg::dist_t'(lbmd3q7_pkg::DIST_MIN);
		return lbmd3q7_pkg::dist_t'(x);
	endfunction

	function automatic cell_out_t collide(input cell_in_t c);
		cell_out_t r;
		longint f [lbmd3q7_pkg::NUM_DIR];
		longint rho, keep, tau, c2, aux, mom, feq;
		rho = 0;
		for (int i = 0; i < lbmd3q7_pkg::NUM_DIR; i++) begin
			f[i] = longint'($signed(c.dirs[i]));
			rho += f[i];
		end
		r.dens = lbmd3q7_pkg::dens_t'(rho);
		tau = longint'(tau_reg);
		c2 = longint'(csq_reg);
		keep = ONE - tau;
		aux = ONE - round_q(4 * c2 * (ONE - longint'(rest_reg)), FRAC);
		for (int i = 0; i < lbmd3q7_pkg::NUM_DIR; i++) begin
			if (c.wall) begin
				r.dirs[i] = clamp_dist(round_q(longint'(damp_reg) * f[lbmd3q7_pkg::OPP[i]],
					FRAC));
			end else begin
				if (i == 0) begin
					feq = round_q(rho * aux, FRAC);
				end else begin
					mom = (i < 3) ? f[1] - f[2] : (i < 5) ? f[3] - f[4] : f[5] - f[6];
					if (i % 2 == 0)
						mom = -mom;
					feq = round_q(c2 * rho + mom * ONE, FRAC + 1);
				end
				r.dirs[i] = clamp_dist(round_q(keep * f[i] + tau * feq, FRAC));
			end
		end
		return r;
	endfunction

	function automatic cell_in_t mk_cell(input int v0, v1, v2, v3, v4, v5, v6, input logic wall);
		cell_in_t c;
		c.dirs[0] = lbmd3q7_pkg::dist_t'(v0);
		c.dirs[1] = lbmd3q7_pkg::dist_t'(v1);
		c.dirs[2] = lbmd3q7_pkg::dist_t'(v2);
		c.dirs[3] = lbmd3q7_pkg::dist_t'(v3);
		c.dirs[4] = lbmd3q7_pkg::dist_t'(v4);
		c.dirs[5] = lbmd3q7_pkg::dist_t'(v5);
		c.dirs[6] = lbmd3q7_pkg::dist_t'(v6);
		c.wall = wall;
		return c;
	endfunction

	function automatic cell_in_t rand_cell();
		cell_in_t c;
		int kind;
		int v;
		kind = $urandom_range(9);
		for (int i = 0; i < lbmd3q7_pkg::NUM_DIR; i++) begin
			case (kind) inside
				[0:3]: v = int'($urandom_range(32768)) - 16384;
				[4:6]: v = $urandom;
				7: begin
					case ($urandom_range(3))
						0: v = lbmd3q7_pkg::DIST_MAX;
						1: v = lbmd3q7_pkg::DIST_MIN;
						2: v = 0;
						default: v = -1;
					endcase
				end
				default: begin
					v = $urandom_range(131071);
					if ($urandom_range(1))
						v = -v - 1;
				end
			endcase
			c.dirs[i] = lbmd3q7_pkg::dist_t'(v);
		end
		c.wall = ($urandom_range(3) == 0);
		return c;
	endfunction

	function automatic logic [15:0] pick_reg_extreme();
		case ($urandom_range(2))
			0: return 16'd0;
			1: return 16'd16384;
			default: return 16'hFFFF;
		endcase
	endfunction

	task automatic write_reg(input lbmd3q7_pkg::cfg_idx_t idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// only called with the pipeline empty
	task automatic set_config(input logic [15:0] tau, damp, csq, rest);
		write_reg(lbmd3q7_pkg::CFG_INV_TAU, tau);
		write_reg(lbmd3q7_pkg::CFG_DAMPING, damp);
		write_reg(lbmd3q7_pkg::CFG_C_SQUARED, csq);
		write_reg(lbmd3q7_pkg::CFG_REST_WEIGHT, rest);
		cfg_we <= 1'b0;
		tau_reg = tau;
		damp_reg = damp[14:0];
		csq_reg = csq[14:0];
		rest_reg = rest[14:0];
		settings_used++;
	endtask

	task automatic send_cell(input cell_in_t c);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		dist_in_0 <= c.dirs[0];
		dist_in_1 <= c.dirs[1];
		dist_in_2 <= c.dirs[2];
		dist_in_3 <= c.dirs[3];
		dist_in_4 <= c.dirs[4];
		dist_in_5 <= c.dirs[5];
		dist_in_6 <= c.dirs[6];
		at_wall <= c.wall;
		@(posedge clk);
		while (in_stall) begin
			input_stall_edges++;
			@(posedge clk);
		end
		expected_cells.push_back(collide(c));
		cells_sent++;
		if (c.wall)
			wall_cells++;
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_cells.size() != 0);
	endtask

	task automatic test_reset_values();
		send_idle_pct = 19;
		recv_idle_pct = 68;
		send_cell(mk_cell(0, 0, 0, 0, 0, 0, 0, 1'b0));
		send_cell(mk_cell(16384, 2048, 1024, 3000, -3000, 500, -700, 1'b0));
		send_cell(mk_cell(lbmd3q7_pkg::DIST_MAX, lbmd3q7_pkg::DIST_MAX, lbmd3q7_pkg::DIST_MAX,
			lbmd3q7_pkg::DIST_MAX, lbmd3q7_pkg::DIST_MAX, lbmd3q7_pkg::DIST_MAX,
			lbmd3q7_pkg::DIST_MAX, 1'b0));
		send_cell(mk_cell(lbmd3q7_pkg::DIST_MIN, lbmd3q7_pkg::DIST_MIN, lbmd3q7_pkg::DIST_MIN,
			lbmd3q7_pkg::DIST_MIN, lbmd3q7_pkg::DIST_MIN, lbmd3q7_pkg::DIST_MIN,
			lbmd3q7_pkg::DIST_MIN, 1'b0));
		send_cell(mk_cell(0, lbmd3q7_pkg::DIST_MAX, lbmd3q7_pkg::DIST_MIN, lbmd3q7_pkg::DIST_MAX,
			lbmd3q7_pkg::DIST_MIN, lbmd3q7_pkg::DIST_MAX, lbmd3q7_pkg::DIST_MIN, 1'b0));
		send_cell(mk_cell(lbmd3q7_pkg::DIST_MIN, lbmd3q7_pkg::DIST_MIN, lbmd3q7_pkg::DIST_MAX,
			lbmd3q7_pkg::DIST_MIN, lbmd3q7_pkg::DIST_MAX, lbmd3q7_pkg::DIST_MIN,
			lbmd3q7_pkg::DIST_MAX, 1'b0));
		send_cell(mk_cell(1000, 2000, 3000, 4000, 5000, 6000, 7000, 1'b1));
		send_cell(mk_cell(lbmd3q7_pkg::DIST_MAX, lbmd3q7_pkg::DIST_MAX, lbmd3q7_pkg::DIST_MAX,
			lbmd3q7_pkg::DIST_MAX, lbmd3q7_pkg::DIST_MAX, lbmd3q7_pkg::DIST_MAX,
			lbmd3q7_pkg::DIST_MAX, 1'b1));
		send_cell(mk_cell(lbmd3q7_pkg::DIST_MIN, lbmd3q7_pkg::DIST_MAX, lbmd3q7_pkg::DIST_MIN,
			-1, 0, 1, -2, 1'b1));
	endtask

	task automatic test_register_extremes();
		wait_drain();
		set_config(16'd0, 16'd0, 16'd0, 16'd0);
		send_cell(mk_cell(5000, -4000, 3000, -2000, 1000, 123, -456, 1'b0));
		send_cell(mk_cell(5000, -4000, 3000, -2000, 1000, 123, -456, 1'b1));
		wait_drain();
		// above range: negative keep factor, rest weight over one, masked top bit
		set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_cell(mk_cell(5000, -4000, 3000, -2000, 1000, 123, -456, 1'b0));
		send_cell(mk_cell(lbmd3q7_pkg::DIST_MAX, lbmd3q7_pkg::DIST_MAX, lbmd3q7_pkg::DIST_MAX,
			lbmd3q7_pkg::DIST_MAX, lbmd3q7_pkg::DIST_MAX, lbmd3q7_pkg::DIST_MAX,
			lbmd3q7_pkg::DIST_MAX, 1'b0));
		send_cell(mk_cell(lbmd3q7_pkg::DIST_MIN, 70000, -70000, 1, -1, lbmd3q7_pkg::DIST_MAX,
			lbmd3q7_pkg::DIST_MIN, 1'b0));
		send_cell(mk_cell(lbmd3q7_pkg::DIST_MIN, lbmd3q7_pkg::DIST_MAX, lbmd3q7_pkg::DIST_MIN,
			100000, -100000, 3, -3, 1'b1));
		wait_drain();
		set_config(16'd16384, 16'd16384, 16'd16384, 16'd16384);
		send_cell(mk_cell(16384, 8192, -8192, 4096, -4096, 2048, -2048, 1'b0));
		send_cell(mk_cell(16384, 8192, -8192, 4096, -4096, 2048, -2048, 1'b1));
	endtask

	task automatic test_backpressure();
		wait_drain();
		set_config(lbmd3q7_pkg::INV_TAU_RST, 16'(lbmd3q7_pkg::DAMPING_RST),
			16'(lbmd3q7_pkg::C_SQUARED_RST), 16'(lbmd3q7_pkg::REST_WEIGHT_RST));
		send_idle_pct = 19;
		recv_idle_pct = 68;
		hold_requests++;
		repeat (40)
			send_cell(rand_cell());
		wait_drain();
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
		logic [15:0] t, dm, cs, rw;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int k = 0; k < count; k++) begin
			if (k % 40 == 0) begin
				wait_drain();
				case ($urandom_range(3))
					0: begin
						t = 16'($urandom_range(32768));
						dm = 16'($urandom_range(16384));
						cs = 16'($urandom_range(16384));
						rw = 16'($urandom_range(16384));
					end
					1: begin
						t = 16'($urandom_range(24576, 8192));
						dm = 16'($urandom_range(16384, 12000));
						cs = 16'($urandom_range(8192, 1024));
						rw = 16'($urandom_range(8192, 2048));
					end
					2: begin
						t = 16'($urandom);
						dm = 16'($urandom);
						cs = 16'($urandom);
						rw = 16'($urandom);
					end
					default: begin
						t = pick_reg_extreme();
						dm = pick_reg_extreme();
						cs = pick_reg_extreme();
						rw = pick_reg_extreme();
					end
				endcase
				set_config(t, dm, cs, rw);
			end
			send_cell(rand_cell());
		end
	endtask

	// receiver: random stalls plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin : check_results
		cell_out_t want, got;
		if (arst_n && out_valid && !out_stall) begin
			got.dirs[0] = dist_out_0;
			got.dirs[1] = dist_out_1;
			got.dirs[2] = dist_out_2;
			got.dirs[3] = dist_out_3;
			got.dirs[4] = dist_out_4;
			got.dirs[5] = dist_out_5;
			got.dirs[6] = dist_out_6;
			got.dens = density;
			if (expected_cells.size() == 0) begin
				errors++;
				$display("%0t: result item expected none got density %0d", $time,
					$signed(got.dens));
			end else begin
				want = expected_cells.pop_front();
				results_checked++;
				for (int i = 0; i < lbmd3q7_pkg::NUM_DIR; i++) begin
					if (got.dirs[i] !== want.dirs[i]) begin
						errors++;
						$display("%0t: dist_out_%0d expected %0d got %0d", $time, i,
							$signed(want.dirs[i]), $signed(got.dirs[i]));
					end
				end
				if (got.dens !== want.dens) begin
					errors++;
					$display("%0t: density expected %0d got %0d", $time,
						$signed(want.dens), $signed(got.dens));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still expected", $time, expected_cells.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin : run_tests
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_register_extremes();
		test_backpressure();
		test_random_traffic(19, 68, 240);
		test_random_traffic(68, 19, 240);
		test_random_traffic(0, 0, 240);
		wait_drain();
		repeat (16) @(posedge clk);
		$display("Ran %0d cells (%0d at wall) over %0d register settings; %0d results checked,",
			cells_sent, wall_cells, settings_used, results_checked);
		$display("input held off on %0d edges, %0d mismatches.", input_stall_edges, errors);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
